// ----- rtl/abic_pkg.sv -----
// Package for the auto backlight idle controller.
// Holds the item and register types, command and register codes, and reset values.
// No dependencies; every other file in rtl uses it by scoped names.
package abic_pkg;

  localparam int unsigned LightW = 16;
  localparam int unsigned DutyW  = 8;
  localparam int unsigned IdleW  = 16;
  localparam int unsigned ProxW  = 11;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  // The subtract unit works on one bit more than a light count.
  localparam int unsigned SubW = LightW + 1;

  // Commands carried by an input item.
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_SAMPLE = 2'd1;
  localparam logic [1:0] CMD_TOUCH  = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_DARK_LUX    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_BRIGHT_LUX  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MIN_DUTY    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_MAX_DUTY    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_OFF_TIMEOUT = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_PROX_THRESH = 3'd5;

  // Reset values.
  localparam logic [LightW-1:0] RST_DARK_LUX     = 16'd1;
  localparam logic [LightW-1:0] RST_BRIGHT_LUX   = 16'd40;
  localparam logic [DutyW-1:0]  RST_MIN_DUTY     = 8'd24;
  localparam logic [DutyW-1:0]  RST_MAX_DUTY     = 8'd255;
  localparam logic [IdleW-1:0]  RST_OFF_TIMEOUT  = 16'd5000;
  localparam logic [ProxW-1:0]  RST_PROX_THRESH  = 11'd30;
  localparam logic [DutyW-1:0]  RST_LEVEL        = 8'd180;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [LightW-1:0] light_count;
    logic [ProxW-1:0]  prox_count;
  } in_item_t;

  typedef struct packed {
    logic [DutyW-1:0] duty;
    logic             screen_off;
    logic [DutyW-1:0] level;
  } out_item_t;

  typedef struct packed {
    logic [LightW-1:0] dark_lux;
    logic [LightW-1:0] bright_lux;
    logic [DutyW-1:0]  min_duty;
    logic [DutyW-1:0]  max_duty;
    logic [IdleW-1:0]  off_timeout_ms;
    logic [ProxW-1:0]  prox_threshold;
  } cfg_t;

  typedef struct packed {
    logic [SubW-1:0] a;
    logic [SubW-1:0] b;
  } sub_req_t;

  typedef struct packed {
    logic [SubW-1:0] diff;
    logic            borrow;
  } sub_rsp_t;

endpackage

// ----- rtl/auto_backlight_idle_controller.sv -----
// Auto backlight idle controller: top level with the configuration registers.
// Depends on abic_pkg and instantiates abic_core (which uses abic_sub).
//
// Input beats carry a command (1 ms tick, light/proximity sample, touch) on
// in_item_i and move when in_valid_i is high and in_stall_o is low. Every
// input beat yields one output beat on out_item_o (duty, screen_off, level),
// moved when out_valid_o is high and out_stall_i low. Configuration beats
// (cfg_index_i, cfg_data_i) are always accepted, unknown indexes are ignored,
// and they should be written only while the block is idle.
// One item is in work at a time. A tick, touch or unknown command goes from
// acceptance straight to the final step, which writes the output register.
// A sample runs three steps on the shared subtractor (window size and
// clamps), a 16x8 multiply, eight restoring-division steps on the same
// subtractor, the target and the level update. With an empty light window
// a sample goes from the window-size step straight to the final step.
// in_stall_o is high from acceptance until the result is written to the
// output register. Reset loads the register defaults, level 180 and idle
// time 0, with no output pending. If the receiver stalls, the result holds
// in the output register; the next item may still be accepted, and its
// result waits until the output register has been emptied.
module auto_backlight_idle_controller (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  abic_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output abic_pkg::out_item_t                 out_item_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [abic_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [abic_pkg::CfgDataW-1:0]       cfg_data_i
);

  abic_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        abic_pkg::REG_DARK_LUX:    cfg_d.dark_lux       = cfg_data_i;
        abic_pkg::REG_BRIGHT_LUX:  cfg_d.bright_lux     = cfg_data_i;
        abic_pkg::REG_MIN_DUTY:    cfg_d.min_duty       = cfg_data_i[abic_pkg::DutyW-1:0];
        abic_pkg::REG_MAX_DUTY:    cfg_d.max_duty       = cfg_data_i[abic_pkg::DutyW-1:0];
        abic_pkg::REG_OFF_TIMEOUT: cfg_d.off_timeout_ms = cfg_data_i;
        abic_pkg::REG_PROX_THRESH: cfg_d.prox_threshold = cfg_data_i[abic_pkg::ProxW-1:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dark_lux       <= abic_pkg::RST_DARK_LUX;
      cfg_q.bright_lux     <= abic_pkg::RST_BRIGHT_LUX;
      cfg_q.min_duty       <= abic_pkg::RST_MIN_DUTY;
      cfg_q.max_duty       <= abic_pkg::RST_MAX_DUTY;
      cfg_q.off_timeout_ms <= abic_pkg::RST_OFF_TIMEOUT;
      cfg_q.prox_threshold <= abic_pkg::RST_PROX_THRESH;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  abic_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- rtl/abic_sub.sv -----
// Shared subtract and compare unit of the auto backlight idle controller.
// Depends on abic_pkg for the request and response types.
module abic_sub (
  input  abic_pkg::sub_req_t req_i,
  output abic_pkg::sub_rsp_t rsp_o
);

  logic [abic_pkg::SubW:0] full;

  // The top bit is the borrow: set when a is below b.
  assign full         = {1'b0, req_i.a} - {1'b0, req_i.b};
  assign rsp_o.diff   = full[abic_pkg::SubW-1:0];
  assign rsp_o.borrow = full[abic_pkg::SubW];

endmodule

// ----- rtl/abic_core.sv -----
// Sequencer and datapath of the auto backlight idle controller.
// Depends on abic_pkg and drives the shared subtract unit abic_sub.
module abic_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  abic_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  abic_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output abic_pkg::out_item_t out_item_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEN  = 3'd1;
  localparam logic [2:0] S_CLO  = 3'd2;
  localparam logic [2:0] S_CHI  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_TGT  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  localparam int unsigned LightW = abic_pkg::LightW;
  localparam int unsigned DutyW  = abic_pkg::DutyW;
  localparam int unsigned ProdW  = LightW + DutyW;

  logic [2:0]                state_q, state_d;
  abic_pkg::in_item_t        item_q, item_d;
  logic [LightW-1:0]         den_q, den_d;
  logic [LightW-1:0]         t_q, t_d;
  logic                      neg_q, neg_d;
  logic [LightW-1:0]         rem_q, rem_d;
  logic [DutyW-1:0]          quo_q, quo_d;
  logic [2:0]                cnt_q, cnt_d;
  logic [DutyW-1:0]          target_q, target_d;
  logic [DutyW-1:0]          level_q, level_d;
  logic [abic_pkg::IdleW-1:0] idle_q, idle_d;
  logic                      out_valid_q, out_valid_d;
  abic_pkg::out_item_t       out_q, out_d;

  abic_pkg::sub_req_t        sub_req;
  abic_pkg::sub_rsp_t        sub_rsp;

  logic                      accept;
  logic                      commit;
  logic                      span_neg;
  logic [DutyW-1:0]          span_mag;
  logic [ProdW-1:0]          prod;
  logic [abic_pkg::SubW-1:0] trial;
  logic [DutyW+1:0]          avg_sum;
  logic                      off;

  abic_sub u_sub (
    .req_i (sub_req),
    .rsp_o (sub_rsp)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign commit      = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign span_neg = cfg_i.min_duty > cfg_i.max_duty;
  assign span_mag = span_neg ? (cfg_i.min_duty - cfg_i.max_duty)
                             : (cfg_i.max_duty - cfg_i.min_duty);
  assign prod     = {{DutyW{1'b0}}, t_q} * {{LightW{1'b0}}, span_mag};
  // Next long-division step brings down the top remaining dividend bit.
  assign trial    = {rem_q, quo_q[DutyW-1]};
  // Three quarters of the old level plus a quarter of the target.
  assign avg_sum  = {1'b0, level_q, 1'b0} + {2'b00, level_q} + {2'b00, target_q};

  always_comb begin
    sub_req.a = '0;
    sub_req.b = '0;
    case (state_q)
      S_DEN: begin
        sub_req.a = {1'b0, cfg_i.bright_lux};
        sub_req.b = {1'b0, cfg_i.dark_lux};
      end
      S_CLO: begin
        sub_req.a = {1'b0, item_q.light_count};
        sub_req.b = {1'b0, cfg_i.dark_lux};
      end
      S_CHI: begin
        sub_req.a = {1'b0, item_q.light_count};
        sub_req.b = {1'b0, cfg_i.bright_lux};
      end
      S_DIV: begin
        sub_req.a = trial;
        sub_req.b = {1'b0, den_q};
      end
      default: begin
        sub_req.a = '0;
        sub_req.b = '0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    den_d       = den_q;
    t_d         = t_q;
    neg_d       = neg_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    target_d    = target_q;
    level_d     = level_q;
    idle_d      = idle_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    off         = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          item_d  = in_item_i;
          state_d = (in_item_i.cmd == abic_pkg::CMD_SAMPLE) ? S_DEN : S_FIN;
        end
      end
      S_DEN: begin
        den_d = sub_rsp.diff[LightW-1:0];
        // An empty light window maps straight to the maximum duty.
        if (sub_rsp.borrow || (sub_rsp.diff == '0)) begin
          target_d = cfg_i.max_duty;
          state_d  = S_FIN;
        end else begin
          state_d = S_CLO;
        end
      end
      S_CLO: begin
        t_d     = sub_rsp.borrow ? '0 : sub_rsp.diff[LightW-1:0];
        state_d = S_CHI;
      end
      S_CHI: begin
        if (!sub_rsp.borrow) begin
          t_d = den_q;
        end
        state_d = S_MUL;
      end
      S_MUL: begin
        // The quotient is at most the duty span, so the top bits of the
        // product already sit below the divisor.
        neg_d   = span_neg;
        rem_d   = prod[ProdW-1:DutyW];
        quo_d   = prod[DutyW-1:0];
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        rem_d = sub_rsp.borrow ? trial[LightW-1:0] : sub_rsp.diff[LightW-1:0];
        quo_d = {quo_q[DutyW-2:0], !sub_rsp.borrow};
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          state_d = S_TGT;
        end
      end
      S_TGT: begin
        target_d = neg_q ? (cfg_i.min_duty - quo_q) : (cfg_i.min_duty + quo_q);
        state_d  = S_FIN;
      end
      S_FIN: begin
        case (item_q.cmd)
          abic_pkg::CMD_TICK: begin
            if (idle_q != '1) begin
              idle_d = idle_q + 1'b1;
            end
          end
          abic_pkg::CMD_SAMPLE: begin
            level_d = avg_sum[DutyW+1:2];
            if (item_q.prox_count > cfg_i.prox_threshold) begin
              idle_d = '0;
            end
          end
          abic_pkg::CMD_TOUCH: begin
            idle_d = '0;
          end
          default: begin
            idle_d = idle_q;
          end
        endcase
        off = idle_d > cfg_i.off_timeout_ms;
        if (commit) begin
          out_d.duty       = off ? '0 : level_d;
          out_d.screen_off = off;
          out_d.level      = level_d;
          out_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end else begin
          level_d = level_q;
          idle_d  = idle_q;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      level_q     <= abic_pkg::RST_LEVEL;
      idle_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      level_q     <= level_d;
      idle_q      <= idle_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    den_q    <= den_d;
    t_q      <= t_d;
    neg_q    <= neg_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    cnt_q    <= cnt_d;
    target_q <= target_d;
    out_q    <= out_d;
  end

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for auto_backlight_idle_controller.
// Depends on abic_pkg and the RTL in rtl; predicts every result beat in
// the testbench and compares it field by field as it leaves the block.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned LightW   = abic_pkg::LightW;
  localparam int unsigned DutyW    = abic_pkg::DutyW;
  localparam int unsigned IdleW    = abic_pkg::IdleW;
  localparam int unsigned ProxW    = abic_pkg::ProxW;
  localparam int unsigned CfgIdxW  = abic_pkg::CfgIdxW;
  localparam int unsigned CfgDataW = abic_pkg::CfgDataW;

  localparam int unsigned CycleLimit  = 200_000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned PhaseItems  = 84;
  localparam int unsigned HoldOff     = 300;
  // The block ignores this command code; it only reports its outputs.
  localparam logic [1:0]  CmdUnused   = 2'd3;

  localparam abic_pkg::cfg_t ResetCfg = '{
    dark_lux:       abic_pkg::RST_DARK_LUX,
    bright_lux:     abic_pkg::RST_BRIGHT_LUX,
    min_duty:       abic_pkg::RST_MIN_DUTY,
    max_duty:       abic_pkg::RST_MAX_DUTY,
    off_timeout_ms: abic_pkg::RST_OFF_TIMEOUT,
    prox_threshold: abic_pkg::RST_PROX_THRESH
  };

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  abic_pkg::in_item_t  in_item   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  abic_pkg::out_item_t out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  // Shadow of the registers and of the block's state.
  abic_pkg::cfg_t     cfg_shadow = ResetCfg;
  logic [DutyW-1:0]   level_est  = abic_pkg::RST_LEVEL;
  logic [IdleW-1:0]   idle_est   = '0;

  abic_pkg::out_item_t pending_readings[$];
  int unsigned        error_count = 0;
  bit                 tx_gaps     = 1'b1;
  bit                 rx_gaps     = 1'b1;
  int unsigned        rx_wait     = 0;
  int unsigned        hold_left   = 0;

  auto_backlight_idle_controller i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [DutyW-1:0] duty_target(input logic [LightW-1:0] light);
    int pos;
    int light_span;
    int duty_span;
    if (cfg_shadow.bright_lux <= cfg_shadow.dark_lux) begin
      return cfg_shadow.max_duty;
    end
    pos = int'(light);
    if (pos < int'(cfg_shadow.dark_lux)) pos = int'(cfg_shadow.dark_lux);
    if (pos > int'(cfg_shadow.bright_lux)) pos = int'(cfg_shadow.bright_lux);
    pos        = pos - int'(cfg_shadow.dark_lux);
    light_span = int'(cfg_shadow.bright_lux) - int'(cfg_shadow.dark_lux);
    duty_span  = int'(cfg_shadow.max_duty) - int'(cfg_shadow.min_duty);
    // Signed division truncates toward zero, so inverted duties stay in range.
    return 8'(int'(cfg_shadow.min_duty) + (pos * duty_span) / light_span);
  endfunction

  function automatic abic_pkg::out_item_t next_reading(input abic_pkg::in_item_t it);
    abic_pkg::out_item_t r;
    logic                dark_screen;
    case (it.cmd)
      abic_pkg::CMD_TICK: begin
        if (idle_est != '1) idle_est = idle_est + 1'b1;
      end
      abic_pkg::CMD_SAMPLE: begin
        level_est = 8'((3 * int'(level_est) + int'(duty_target(it.light_count))) / 4);
        if (it.prox_count > cfg_shadow.prox_threshold) idle_est = '0;
      end
      abic_pkg::CMD_TOUCH: begin
        idle_est = '0;
      end
      default: begin
      end
    endcase
    dark_screen  = idle_est > cfg_shadow.off_timeout_ms;
    r.duty       = dark_screen ? '0 : level_est;
    r.screen_off = dark_screen;
    r.level      = level_est;
    return r;
  endfunction

  // ------------------------------------------------------------ drive / check

  task automatic send_item(input abic_pkg::in_item_t it);
    int unsigned gap;
    gap = tx_gaps ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk_i); while (in_stall);
    pending_readings.push_back(next_reading(it));
  endtask

  task automatic send_cmd(input logic [1:0] cmd, input logic [LightW-1:0] light,
                          input logic [ProxW-1:0] prox);
    abic_pkg::in_item_t it;
    it.cmd         = cmd;
    it.light_count = light;
    it.prox_count  = prox;
    send_item(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_readings.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Writes all six registers back to back; call only with the block idle.
  task automatic load_settings(input abic_pkg::cfg_t c);
    logic [CfgIdxW-1:0]  idx [6];
    logic [CfgDataW-1:0] vals[6];
    idx = '{abic_pkg::REG_DARK_LUX, abic_pkg::REG_BRIGHT_LUX, abic_pkg::REG_MIN_DUTY,
            abic_pkg::REG_MAX_DUTY, abic_pkg::REG_OFF_TIMEOUT, abic_pkg::REG_PROX_THRESH};
    vals[0] = c.dark_lux;
    vals[1] = c.bright_lux;
    vals[2] = 16'(c.min_duty);
    vals[3] = 16'(c.max_duty);
    vals[4] = c.off_timeout_ms;
    vals[5] = 16'(c.prox_threshold);
    for (int i = 0; i < 6; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready);
    end
    cfg_valid  <= 1'b0;
    cfg_shadow = c;
  endtask

  task automatic check_reading(input abic_pkg::out_item_t got);
    abic_pkg::out_item_t want;
    if (pending_readings.size() == 0) begin
      $display("%0t: result beat with nothing expected: duty=%0d off=%0b level=%0d",
               $time, got.duty, got.screen_off, got.level);
      error_count++;
      return;
    end
    want = pending_readings.pop_front();
    if (got.duty !== want.duty) begin
      $display("%0t: duty expected %0d actual %0d", $time, want.duty, got.duty);
      error_count++;
    end
    if (got.screen_off !== want.screen_off) begin
      $display("%0t: screen_off expected %0b actual %0b", $time, want.screen_off,
               got.screen_off);
      error_count++;
    end
    if (got.level !== want.level) begin
      $display("%0t: level expected %0d actual %0d", $time, want.level, got.level);
      error_count++;
    end
  endtask

  // Receiver: takes a beat, then stalls for a drawn number of cycles. A long
  // hold-off from its own counter can hold the stall high on top of that.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        check_reading(out_item);
        rx_wait = rx_gaps ? $urandom_range(0, 12) : 0;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_stall <= (rx_wait > 0) || (hold_left > 0);
    end
  end

  always @(posedge clk_i) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // ------------------------------------------------------------------- stimulus

  function automatic abic_pkg::in_item_t random_item();
    abic_pkg::in_item_t it;
    int unsigned        pick;
    int                 lo;
    int                 hi;
    pick = $urandom_range(0, 99);
    if (pick < 45)      it.cmd = abic_pkg::CMD_TICK;
    else if (pick < 80) it.cmd = abic_pkg::CMD_SAMPLE;
    else if (pick < 95) it.cmd = abic_pkg::CMD_TOUCH;
    else                it.cmd = CmdUnused;
    if ($urandom_range(0, 1) == 0) begin
      it.light_count = 16'($urandom());
    end else begin
      lo = int'(cfg_shadow.dark_lux) - 4;
      hi = int'(cfg_shadow.bright_lux) + 4;
      if (lo < 0) lo = 0;
      if (hi > 65535) hi = 65535;
      it.light_count = 16'($urandom_range(hi, lo));
    end
    if ($urandom_range(0, 1) == 0) begin
      it.prox_count = 11'($urandom());
    end else begin
      lo = int'(cfg_shadow.prox_threshold) - 2;
      hi = int'(cfg_shadow.prox_threshold) + 2;
      if (lo < 0) lo = 0;
      if (hi > 2047) hi = 2047;
      it.prox_count = 11'($urandom_range(hi, lo));
    end
    return it;
  endfunction

  function automatic abic_pkg::cfg_t random_settings(input int unsigned kind);
    abic_pkg::cfg_t c;
    c = ResetCfg;
    case (kind)
      0: begin
        c.dark_lux       = '0;
        c.bright_lux     = '1;
        c.min_duty       = '0;
        c.max_duty       = '1;
        c.off_timeout_ms = 16'd1;
        c.prox_threshold = '0;
      end
      1: begin
        c.dark_lux       = 16'($urandom_range(0, 1000));
        c.bright_lux     = c.dark_lux + 16'($urandom_range(1, 2000));
        c.min_duty       = 8'($urandom_range(0, 120));
        c.max_duty       = 8'($urandom_range(130, 255));
        c.off_timeout_ms = 16'($urandom_range(1, 40));
        c.prox_threshold = 11'($urandom_range(0, 2047));
      end
      2: begin
        c.dark_lux       = 16'($urandom_range(0, 300));
        c.bright_lux     = 16'($urandom_range(200, 900));
        c.min_duty       = 8'($urandom_range(128, 255));
        c.max_duty       = 8'($urandom_range(0, 127));
        c.off_timeout_ms = 16'hFFFE;
        c.prox_threshold = '1;
      end
      3: begin
        c.dark_lux       = 16'($urandom());
        c.bright_lux     = 16'($urandom());
        c.min_duty       = 8'($urandom());
        c.max_duty       = 8'($urandom());
        c.off_timeout_ms = 16'($urandom_range(1, 20)) | (16'($urandom()) & 16'h8000);
        c.prox_threshold = 11'($urandom());
      end
      default: begin
      end
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------- test tasks

  task automatic test_mapping_at_reset();
    send_cmd(abic_pkg::CMD_TOUCH,  16'd0,     11'd0);
    send_cmd(abic_pkg::CMD_SAMPLE, 16'd0,     11'd0);
    send_cmd(abic_pkg::CMD_SAMPLE, 16'd1,     11'd30);
    send_cmd(abic_pkg::CMD_SAMPLE, 16'd20,    11'd31);
    send_cmd(abic_pkg::CMD_SAMPLE, 16'd40,    11'd2047);
    send_cmd(abic_pkg::CMD_SAMPLE, 16'd41,    11'd5);
    send_cmd(abic_pkg::CMD_SAMPLE, 16'hFFFF,  11'd0);
    send_cmd(CmdUnused,            16'hFFFF,  11'h7FF);
    send_cmd(abic_pkg::CMD_TICK,   16'hFFFF,  11'h7FF);
    wait_drained();
  endtask

  // Window with bright not above dark: the target is always max_duty.
  task automatic test_empty_window();
    abic_pkg::cfg_t c;
    c = ResetCfg;
    c.dark_lux   = 16'd500;
    c.bright_lux = 16'd500;
    c.max_duty   = 8'd90;
    load_settings(c);
    send_cmd(abic_pkg::CMD_SAMPLE, 16'd0,    11'd0);
    send_cmd(abic_pkg::CMD_SAMPLE, 16'hFFFF, 11'd0);
    wait_drained();
    c.dark_lux   = 16'hFFFF;
    c.bright_lux = 16'd0;
    load_settings(c);
    send_cmd(abic_pkg::CMD_SAMPLE, 16'd1234, 11'd0);
    wait_drained();
  endtask

  task automatic test_inverted_duties();
    abic_pkg::cfg_t c;
    c = ResetCfg;
    c.dark_lux   = 16'd0;
    c.bright_lux = 16'hFFFF;
    c.min_duty   = 8'd255;
    c.max_duty   = 8'd0;
    load_settings(c);
    send_cmd(abic_pkg::CMD_SAMPLE, 16'd0,     11'd0);
    send_cmd(abic_pkg::CMD_SAMPLE, 16'hFFFF,  11'd0);
    send_cmd(abic_pkg::CMD_SAMPLE, 16'd100,   11'd0);
    send_cmd(abic_pkg::CMD_SAMPLE, 16'd32768, 11'd0);
    wait_drained();
    c.min_duty = 8'd77;
    c.max_duty = 8'd77;
    load_settings(c);
    send_cmd(abic_pkg::CMD_SAMPLE, 16'd4321, 11'd0);
    wait_drained();
  endtask

  // A zero timeout turns the screen off after one idle millisecond; a timeout
  // of one needs two.
  task automatic test_timeout_edges();
    abic_pkg::cfg_t c;
    c = ResetCfg;
    c.off_timeout_ms = 16'd0;
    load_settings(c);
    send_cmd(abic_pkg::CMD_TOUCH,  16'd0, 11'd0);
    send_cmd(abic_pkg::CMD_TICK,   16'd0, 11'd0);
    send_cmd(abic_pkg::CMD_SAMPLE, 16'd9, 11'd31);
    send_cmd(abic_pkg::CMD_TICK,   16'd0, 11'd0);
    send_cmd(abic_pkg::CMD_SAMPLE, 16'd9, 11'd30);
    wait_drained();
    c.off_timeout_ms = 16'd1;
    load_settings(c);
    send_cmd(abic_pkg::CMD_TOUCH, 16'd0, 11'd0);
    send_cmd(abic_pkg::CMD_TICK,  16'd0, 11'd0);
    send_cmd(abic_pkg::CMD_TICK,  16'd0, 11'd0);
    wait_drained();
  endtask

  // The two largest timeouts keep the screen on through a short idle run,
  // with items and results moving back to back.
  task automatic test_large_timeouts();
    abic_pkg::cfg_t c;
    c = ResetCfg;
    c.off_timeout_ms = 16'hFFFF;
    load_settings(c);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    send_cmd(abic_pkg::CMD_TOUCH, 16'd0, 11'd0);
    for (int i = 0; i < 8; i++) send_cmd(abic_pkg::CMD_TICK, 16'd0, 11'd0);
    wait_drained();
    c.off_timeout_ms = 16'hFFFE;
    load_settings(c);
    send_cmd(abic_pkg::CMD_TICK,   16'd0,  11'd0);
    send_cmd(abic_pkg::CMD_SAMPLE, 16'd25, 11'd30);
    send_cmd(abic_pkg::CMD_TOUCH,  16'd0,  11'd0);
    wait_drained();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  task automatic test_random_traffic();
    for (int unsigned phase = 0; phase < 5; phase++) begin
      load_settings(random_settings(phase));
      // Phase 3 parks the receiver while items keep coming, so the block
      // fills up and has to stall its input. Phase 4 runs without gaps.
      if (phase == 3) hold_left <= HoldOff;
      tx_gaps = (phase != 4);
      rx_gaps = (phase != 4);
      for (int unsigned n = 0; n < PhaseItems; n++) send_item(random_item());
      wait_drained();
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_mapping_at_reset();
    test_empty_window();
    test_inverted_duties();
    test_timeout_edges();
    test_large_timeouts();
    test_random_traffic();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: run did not finish in time", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
